// ===== hdl/tls_pkg.sv =====
// ----------------------------------------------------------------------------
// tls_pkg
// shared types, codes and helpers of the telnet line statistics block
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int LEN_BITS   = 16;
  localparam int COUNT_BITS = 32;

  localparam logic [7:0] IAC_CODE = 8'd255;
  localparam logic [7:0] NEG_LOW  = 8'd251;
  localparam logic [7:0] NEG_HIGH = 8'd254;
  localparam logic [7:0] CR_CODE  = 8'd13;
  localparam logic [7:0] LF_CODE  = 8'd10;

  localparam logic [LEN_BITS-1:0] LIMIT_RESET = 16'd80;

  // option parser modes
  localparam logic [1:0] MODE_NORMAL    = 2'd0;
  localparam logic [1:0] MODE_AFTER_IAC = 2'd1;
  localparam logic [1:0] MODE_SKIP      = 2'd2;

  // register indexes, decoded from paddr[2]
  localparam logic REG_DETECT_ENABLE     = 1'b0;
  localparam logic REG_NORMAL_LINE_LIMIT = 1'b1;

  typedef struct packed {
    logic                detect_enable;
    logic [LEN_BITS-1:0] normal_line_limit;
  } cfg_t;

  typedef struct packed {
    logic                  signature_seen;
    logic [LEN_BITS-1:0]   packet_length;
    logic [COUNT_BITS-1:0] byte_total;
    logic [COUNT_BITS-1:0] line_total;
    logic [COUNT_BITS-1:0] normal_line_total;
    logic [COUNT_BITS-1:0] ascii_total;
  } res_t;

  function automatic logic [LEN_BITS-1:0] sat_inc_len(input logic [LEN_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc_cnt(input logic [COUNT_BITS-1:0] v,
                                                        input logic inc);
    return (inc && v != '1) ? v + 1'b1 : v;
  endfunction

endpackage

// ===== hdl/telnet_line_statistics.sv =====
// ----------------------------------------------------------------------------
// telnet_line_statistics
// telnet signature flag and running line statistics over tcp payload bytes
// ----------------------------------------------------------------------------
// Takes one payload byte per clock with no gaps needed between packets. A
// byte passes an input register and is parsed from there, where the parser
// state and the four saturating totals update; the report of a packet is
// loaded into the output register on the cycle its last byte is parsed.
// The rate is one byte per cycle, set by the update of parser state and
// totals; input stalls only while a report sits in the output register and
// m_tready is low. Clearing detect_enable drops bytes without any report.
module telnet_line_statistics (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // data_byte
  input  logic          s_tlast,   // packet_end
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [143:0]  m_tdata,   // packet_length, byte_total, line_total,
                                   // normal_line_total, ascii_total
  output logic [0:0]    m_tuser,   // signature_seen
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import tls_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       out_word;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic       step;
  logic       res_valid;

  tls_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign step      = advance && cfg.detect_enable;
  assign res_valid = step && in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  tls_core u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .data_byte         (in_byte),
    .packet_end        (in_last),
    .normal_line_limit (cfg.normal_line_limit),
    .res               (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word <= res;
    end
  end

  assign m_tdata = {out_word.ascii_total, out_word.normal_line_total, out_word.line_total,
                    out_word.byte_total, out_word.packet_length};
  assign m_tuser = out_word.signature_seen;

endmodule

// ===== hdl/tls_regs.sv =====
// ----------------------------------------------------------------------------
// tls_regs
// apb configuration registers: detect enable and normal line limit
// ----------------------------------------------------------------------------
module tls_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output tls_pkg::cfg_t      cfg
);
  import tls_pkg::*;

  logic wr;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_enable     <= 1'b1;
      cfg.normal_line_limit <= LIMIT_RESET;
    end else if (wr) begin
      unique case (reg_sel)
        REG_DETECT_ENABLE:     cfg.detect_enable     <= pwdata[0];
        REG_NORMAL_LINE_LIMIT: cfg.normal_line_limit <= pwdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_DETECT_ENABLE:     prdata = {31'd0, cfg.detect_enable};
      REG_NORMAL_LINE_LIMIT: prdata = {{(32-LEN_BITS){1'b0}}, cfg.normal_line_limit};
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== hdl/tls_core.sv =====
// ----------------------------------------------------------------------------
// tls_core
// per-byte telnet parser, per-packet state and saturating running totals
// ----------------------------------------------------------------------------
module tls_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [7:0]                    data_byte,
  input  logic                          packet_end,
  input  logic [tls_pkg::LEN_BITS-1:0]  normal_line_limit,
  output tls_pkg::res_t                 res
);
  import tls_pkg::*;

  logic [LEN_BITS-1:0]   byte_index;
  logic [1:0]            option_mode;
  logic [7:0]            previous_char;
  logic [LEN_BITS-1:0]   line_start;
  logic [LEN_BITS-1:0]   option_bytes;
  logic                  packet_suppressed;
  logic                  first_byte_iac;
  logic [COUNT_BITS-1:0] byte_count;
  logic [COUNT_BITS-1:0] line_count;
  logic [COUNT_BITS-1:0] normal_line_count;
  logic [COUNT_BITS-1:0] ascii_count;

  logic [1:0]            option_mode_next;
  logic [7:0]            previous_char_next;
  logic [LEN_BITS-1:0]   line_start_next;
  logic [LEN_BITS-1:0]   option_bytes_next;
  logic                  first_byte_iac_next;
  logic                  suppress_now;
  logic                  inc_byte, inc_line, inc_normal, inc_ascii;
  logic signed [LEN_BITS+1:0] line_len;
  logic                  line_normal;
  logic [COUNT_BITS-1:0] byte_count_next;
  logic [COUNT_BITS-1:0] line_count_next;
  logic [COUNT_BITS-1:0] normal_line_count_next;
  logic [COUNT_BITS-1:0] ascii_count_next;

  assign first_byte_iac_next = (byte_index == '0) ? (data_byte == IAC_CODE) : first_byte_iac;
  assign suppress_now = !packet_suppressed && (byte_index == LEN_BITS'(2))
                        && first_byte_iac_next && (option_mode == MODE_SKIP);

  assign line_len = $signed({2'b00, byte_index}) - $signed({2'b00, line_start})
                    - $signed({2'b00, option_bytes});
  assign line_normal = line_len[LEN_BITS+1]
                       || (line_len[LEN_BITS:0] <= {1'b0, normal_line_limit});

  always_comb begin
    option_mode_next   = option_mode;
    previous_char_next = previous_char;
    line_start_next    = line_start;
    option_bytes_next  = option_bytes;
    inc_byte   = 1'b0;
    inc_line   = 1'b0;
    inc_normal = 1'b0;
    inc_ascii  = 1'b0;
    if (!packet_suppressed && !suppress_now) begin
      unique case (option_mode)
        MODE_AFTER_IAC: begin
          option_mode_next = MODE_NORMAL;
          if (data_byte == IAC_CODE) begin
            inc_byte           = 1'b1;
            previous_char_next = data_byte;
          end else begin
            option_bytes_next = sat_inc_len(option_bytes);
            if (data_byte >= NEG_LOW && data_byte <= NEG_HIGH) begin
              option_mode_next = MODE_SKIP;
            end
          end
        end
        MODE_SKIP: begin
          option_bytes_next = sat_inc_len(option_bytes);
          option_mode_next  = MODE_NORMAL;
        end
        MODE_NORMAL: begin
          if (data_byte == LF_CODE && previous_char == CR_CODE) begin
            inc_byte           = 1'b1;
            previous_char_next = data_byte;
          end else if (data_byte == LF_CODE || data_byte == CR_CODE) begin
            inc_byte           = 1'b1;
            inc_line           = 1'b1;
            inc_normal         = line_normal;
            option_bytes_next  = '0;
            line_start_next    = byte_index;
            previous_char_next = data_byte;
          end else if (data_byte == IAC_CODE) begin
            option_bytes_next = sat_inc_len(option_bytes);
            option_mode_next  = MODE_AFTER_IAC;
          end else begin
            inc_byte           = 1'b1;
            inc_ascii          = (data_byte != 8'd0) && !data_byte[7];
            previous_char_next = data_byte;
          end
        end
        default: option_mode_next = MODE_NORMAL;
      endcase
    end
  end

  assign byte_count_next        = sat_inc_cnt(byte_count, inc_byte);
  assign line_count_next        = sat_inc_cnt(line_count, inc_line);
  assign normal_line_count_next = sat_inc_cnt(normal_line_count, inc_normal);
  assign ascii_count_next       = sat_inc_cnt(ascii_count, inc_ascii);

  assign res.signature_seen    = packet_suppressed | suppress_now;
  assign res.packet_length     = sat_inc_len(byte_index);
  assign res.byte_total        = byte_count_next;
  assign res.line_total        = line_count_next;
  assign res.normal_line_total = normal_line_count_next;
  assign res.ascii_total       = ascii_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index        <= '0;
      option_mode       <= MODE_NORMAL;
      previous_char     <= '0;
      line_start        <= '0;
      option_bytes      <= '0;
      packet_suppressed <= 1'b0;
      first_byte_iac    <= 1'b0;
      byte_count        <= '0;
      line_count        <= '0;
      normal_line_count <= '0;
      ascii_count       <= '0;
    end else if (step) begin
      byte_count        <= byte_count_next;
      line_count        <= line_count_next;
      normal_line_count <= normal_line_count_next;
      ascii_count       <= ascii_count_next;
      if (packet_end) begin
        byte_index        <= '0;
        option_mode       <= MODE_NORMAL;
        previous_char     <= '0;
        line_start        <= '0;
        option_bytes      <= '0;
        packet_suppressed <= 1'b0;
        first_byte_iac    <= 1'b0;
      end else begin
        byte_index        <= sat_inc_len(byte_index);
        option_mode       <= option_mode_next;
        previous_char     <= previous_char_next;
        line_start        <= line_start_next;
        option_bytes      <= option_bytes_next;
        packet_suppressed <= packet_suppressed | suppress_now;
        first_byte_iac    <= first_byte_iac_next;
      end
    end
  end

endmodule
